// ----- rtl/core/pva_pkg.sv -----
// Shared types and constants for the polyphonic voice allocator.
`default_nettype none
package pva_pkg;

	localparam int MODE_W  = 2;
	localparam int NOTE_W  = 7;
	localparam int SLOT_W  = 4;
	localparam int OUTC_W  = 3;
	localparam int MASK_W  = 16;
	localparam int REL_W   = 20;

	localparam logic [REL_W-1:0] REL_TICKS_RST = REL_W'(14400);

	localparam logic [MODE_W-1:0] MODE_NOTE_ON  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_NOTE_OFF = 2'd1;
	localparam logic [MODE_W-1:0] MODE_TICK     = 2'd2;
	localparam logic [MODE_W-1:0] MODE_ALL_OFF  = 2'd3;

	localparam logic [OUTC_W-1:0] OUTC_RETRIG     = 3'd0;
	localparam logic [OUTC_W-1:0] OUTC_FREE_SLOT  = 3'd1;
	localparam logic [OUTC_W-1:0] OUTC_STOLE_REL  = 3'd2;
	localparam logic [OUTC_W-1:0] OUTC_STOLE_HELD = 3'd3;
	localparam logic [OUTC_W-1:0] OUTC_RELEASED   = 3'd4;
	localparam logic [OUTC_W-1:0] OUTC_NO_MATCH   = 3'd5;
	localparam logic [OUTC_W-1:0] OUTC_TICK       = 3'd6;
	localparam logic [OUTC_W-1:0] OUTC_ALL_OFF    = 3'd7;

	typedef struct packed {
		logic load;
		logic scan_rd;
		logic commit;
		logic emit;
	} pva_ctl_t;

endpackage
`default_nettype wire

// ----- rtl/core/pva_ctrl.sv -----
// Sequencer for the voice allocator: accept, voice scan, commit, result handoff.
`default_nettype none
module pva_ctrl import pva_pkg::*; #(
	parameter int NUM_VOICES = 16,
	localparam int IDX_W = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	input  wire logic [MODE_W-1:0]     mode,
	input  wire logic                  out_free,
	output logic                       in_stall,
	output pva_ctl_t                   ctl,
	output logic [IDX_W-1:0]           rd_idx
);

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_VOICES - 1);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SCAN   = 3'd1;
	localparam logic [2:0] ST_DRAIN  = 3'd2;
	localparam logic [2:0] ST_COMMIT = 3'd3;
	localparam logic [2:0] ST_EMIT   = 3'd4;

	logic [2:0]       state_q, state_d;
	logic [IDX_W-1:0] idx_q, idx_d;

	always_comb begin
		state_d     = state_q;
		idx_d       = idx_q;
		ctl         = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					ctl.load = 1'b1;
					idx_d    = '0;
					state_d  = (mode == MODE_ALL_OFF) ? ST_COMMIT : ST_SCAN;
				end
			end
			ST_SCAN: begin
				ctl.scan_rd = 1'b1;
				if (idx_q == LAST_IDX) begin
					state_d = ST_DRAIN;
				end else begin
					idx_d = idx_q + 1'b1;
				end
			end
			ST_DRAIN: begin
				state_d = ST_COMMIT;
			end
			ST_COMMIT: begin
				ctl.commit = 1'b1;
				state_d    = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_free) begin
					ctl.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign rd_idx   = idx_q;
	assign in_stall = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/pva_dp.sv -----
// Voice table, scan trackers, commit logic and output register of the voice allocator.
`default_nettype none
module pva_dp import pva_pkg::*; #(
	parameter int NUM_VOICES = 16,
	parameter int AGE_BITS   = 32,
	localparam int IDX_W = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire pva_ctl_t              ctl,
	input  wire logic [IDX_W-1:0]      rd_idx,
	input  wire logic [MODE_W-1:0]     mode,
	input  wire logic [NOTE_W-1:0]     note,
	input  wire logic                  cfg_we,
	input  wire logic [REL_W-1:0]      cfg_wdata,
	input  wire logic                  out_stall,
	output logic                       out_free,
	output logic                       out_valid,
	output logic [SLOT_W-1:0]          voice_slot,
	output logic [OUTC_W-1:0]          outcome,
	output logic [NOTE_W-1:0]          evicted_note,
	output logic [MASK_W-1:0]          freed_mask,
	output logic [MASK_W-1:0]          sounding_mask
);

	logic [NOTE_W-1:0]   note_mem [NUM_VOICES];
	logic [AGE_BITS-1:0] age_mem  [NUM_VOICES];
	logic [REL_W-1:0]    cnt_mem  [NUM_VOICES];

	logic [MODE_W-1:0]     mode_q;
	logic [NOTE_W-1:0]     note_q;
	logic [REL_W-1:0]      rel_ticks_q;
	logic [NUM_VOICES-1:0] held_q;
	logic [NUM_VOICES-1:0] rel_q;
	logic [NUM_VOICES-1:0] freed_q;
	logic [AGE_BITS-1:0]   age_stamp_q;

	logic                vld_s1;
	logic [IDX_W-1:0]    idx_s1;
	logic [NOTE_W-1:0]   rd_note_s1;
	logic [AGE_BITS-1:0] rd_age_s1;
	logic [REL_W-1:0]    rd_cnt_s1;

	logic                match_found_q, free_found_q, rel_found_q, hld_found_q;
	logic [IDX_W-1:0]    match_idx_q, free_idx_q, rel_idx_q, hld_idx_q;
	logic [AGE_BITS-1:0] rel_age_q, hld_age_q;
	logic [NOTE_W-1:0]   rel_note_q, hld_note_q;

	logic [IDX_W-1:0]    res_slot_q;
	logic [OUTC_W-1:0]   res_outc_q;
	logic [NOTE_W-1:0]   res_evict_q;

	logic              cur_held, cur_rel, cur_snd, note_eq;
	logic              match_hit, free_hit, rel_hit, hld_hit;
	logic [REL_W-1:0]  cnt_inc;
	logic              tick_act, tick_free;

	logic              tgt_ok;
	logic [IDX_W-1:0]  tgt;
	logic [OUTC_W-1:0] outc_c;
	logic [NOTE_W-1:0] evict_c;
	logic              on_wr, off_wr;

	always_comb begin
		cur_held  = held_q[idx_s1];
		cur_rel   = rel_q[idx_s1];
		cur_snd   = cur_held | cur_rel;
		note_eq   = (rd_note_s1 == note_q);
		match_hit = vld_s1 && !match_found_q && note_eq &&
			((mode_q == MODE_NOTE_ON) ? cur_snd : cur_held);
		free_hit  = vld_s1 && !free_found_q && !cur_snd;
		rel_hit   = vld_s1 && cur_rel && (!rel_found_q || (rd_age_s1 < rel_age_q));
		hld_hit   = vld_s1 && cur_held && (!hld_found_q || (rd_age_s1 < hld_age_q));
		cnt_inc   = rd_cnt_s1 + 1'b1;
		tick_act  = vld_s1 && (mode_q == MODE_TICK) && cur_rel;
		tick_free = tick_act && (cnt_inc >= rel_ticks_q);
	end

	always_comb begin
		tgt_ok  = 1'b0;
		tgt     = '0;
		outc_c  = OUTC_NO_MATCH;
		evict_c = '0;
		case (mode_q)
			MODE_NOTE_ON: begin
				if (match_found_q) begin
					tgt_ok = 1'b1;
					tgt    = match_idx_q;
					outc_c = OUTC_RETRIG;
				end else if (free_found_q) begin
					tgt_ok = 1'b1;
					tgt    = free_idx_q;
					outc_c = OUTC_FREE_SLOT;
				end else if (rel_found_q) begin
					tgt_ok  = 1'b1;
					tgt     = rel_idx_q;
					outc_c  = OUTC_STOLE_REL;
					evict_c = rel_note_q;
				end else if (hld_found_q) begin
					tgt_ok  = 1'b1;
					tgt     = hld_idx_q;
					outc_c  = OUTC_STOLE_HELD;
					evict_c = hld_note_q;
				end
			end
			MODE_NOTE_OFF: begin
				if (match_found_q) begin
					tgt_ok = 1'b1;
					tgt    = match_idx_q;
					outc_c = OUTC_RELEASED;
				end
			end
			MODE_TICK: begin
				outc_c = OUTC_TICK;
			end
			default: begin
				outc_c = OUTC_ALL_OFF;
			end
		endcase
		on_wr  = ctl.commit && tgt_ok && (mode_q == MODE_NOTE_ON);
		off_wr = ctl.commit && tgt_ok && (mode_q == MODE_NOTE_OFF);
	end

	always_ff @(posedge clk) begin
		if (on_wr) begin
			note_mem[tgt] <= note_q;
			age_mem[tgt]  <= age_stamp_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_act) begin
			cnt_mem[idx_s1] <= cnt_inc;
		end else if (on_wr || off_wr) begin
			cnt_mem[tgt] <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.scan_rd) begin
			rd_note_s1 <= note_mem[rd_idx];
			rd_age_s1  <= age_mem[rd_idx];
			rd_cnt_s1  <= cnt_mem[rd_idx];
			idx_s1     <= rd_idx;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			mode_q <= mode;
			note_q <= note;
		end
		if (match_hit) begin
			match_idx_q <= idx_s1;
		end
		if (free_hit) begin
			free_idx_q <= idx_s1;
		end
		if (rel_hit) begin
			rel_idx_q  <= idx_s1;
			rel_age_q  <= rd_age_s1;
			rel_note_q <= rd_note_s1;
		end
		if (hld_hit) begin
			hld_idx_q  <= idx_s1;
			hld_age_q  <= rd_age_s1;
			hld_note_q <= rd_note_s1;
		end
		if (ctl.commit) begin
			res_slot_q  <= tgt_ok ? tgt : '0;
			res_outc_q  <= outc_c;
			res_evict_q <= evict_c;
		end
		if (ctl.emit) begin
			voice_slot    <= SLOT_W'(res_slot_q);
			outcome       <= res_outc_q;
			evicted_note  <= res_evict_q;
			freed_mask    <= MASK_W'(freed_q);
			sounding_mask <= MASK_W'(held_q | rel_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rel_ticks_q   <= REL_TICKS_RST;
			held_q        <= '0;
			rel_q         <= '0;
			freed_q       <= '0;
			age_stamp_q   <= '0;
			vld_s1        <= 1'b0;
			match_found_q <= 1'b0;
			free_found_q  <= 1'b0;
			rel_found_q   <= 1'b0;
			hld_found_q   <= 1'b0;
			out_valid     <= 1'b0;
		end else begin
			if (cfg_we) begin
				rel_ticks_q <= cfg_wdata;
			end
			vld_s1 <= ctl.scan_rd;
			if (ctl.load) begin
				match_found_q <= 1'b0;
				free_found_q  <= 1'b0;
				rel_found_q   <= 1'b0;
				hld_found_q   <= 1'b0;
				freed_q       <= '0;
			end else begin
				if (match_hit) match_found_q <= 1'b1;
				if (free_hit)  free_found_q  <= 1'b1;
				if (rel_hit)   rel_found_q   <= 1'b1;
				if (hld_hit)   hld_found_q   <= 1'b1;
				if (tick_free) freed_q[idx_s1] <= 1'b1;
			end
			if (tick_free) begin
				held_q[idx_s1] <= 1'b0;
				rel_q[idx_s1]  <= 1'b0;
			end
			if (on_wr) begin
				held_q[tgt] <= 1'b1;
				rel_q[tgt]  <= 1'b0;
				age_stamp_q <= age_stamp_q + 1'b1;
			end
			if (off_wr) begin
				held_q[tgt] <= 1'b0;
				rel_q[tgt]  <= 1'b1;
			end
			if (ctl.commit && (mode_q == MODE_ALL_OFF)) begin
				held_q <= '0;
				rel_q  <= '0;
			end
			if (ctl.emit) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	assign out_free = !out_valid || !out_stall;

endmodule
`default_nettype wire

// ----- rtl/core/polyphonic_voice_allocator.sv -----
// Polyphonic voice allocator with oldest-voice stealing: top level.
//
// Input channel (in_valid/in_stall, fields mode and note) carries one command
// per transaction: note on, note off, sample tick or all voices off. Output
// channel (out_valid/out_stall) returns exactly one result per command: the
// chosen or released voice, an outcome code, the evicted note, the voices
// freed by a tick and the voices sounding afterwards.
// Note on, note off and tick walk the voice table one voice per cycle through
// a single read port of the note, age and release-count memories; after
// acceptance such a command passes through the scan, drain, commit and emit
// states, holding the input channel until its result is moved to the output
// register; all off skips the scan and drain states.
// One command is in work at a time; a new one is taken once the previous
// result has moved to the output register, even while that result is stalled.
// If out_stall holds the output register full, the finished command waits.
// cfg_we writes release_ticks; write it only while the block is idle.
// Reset silences every voice, clears the age counter and sets release_ticks
// to 14400; the table memories need no clearing.
`default_nettype none
module polyphonic_voice_allocator import pva_pkg::*; #(
	parameter int NUM_VOICES = 16,
	parameter int AGE_BITS   = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [MODE_W-1:0] mode,
	input  wire logic [NOTE_W-1:0] note,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [SLOT_W-1:0]      voice_slot,
	output logic [OUTC_W-1:0]      outcome,
	output logic [NOTE_W-1:0]      evicted_note,
	output logic [MASK_W-1:0]      freed_mask,
	output logic [MASK_W-1:0]      sounding_mask,
	input  wire logic              cfg_we,
	input  wire logic [REL_W-1:0]  cfg_wdata
);

	localparam int IDX_W = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;

	pva_ctl_t         ctl;
	logic [IDX_W-1:0] rd_idx;
	logic             out_free;

	pva_ctrl #(
		.NUM_VOICES(NUM_VOICES)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.mode     (mode),
		.out_free (out_free),
		.in_stall (in_stall),
		.ctl      (ctl),
		.rd_idx   (rd_idx)
	);

	pva_dp #(
		.NUM_VOICES(NUM_VOICES),
		.AGE_BITS  (AGE_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.rd_idx        (rd_idx),
		.mode          (mode),
		.note          (note),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.out_stall     (out_stall),
		.out_free      (out_free),
		.out_valid     (out_valid),
		.voice_slot    (voice_slot),
		.outcome       (outcome),
		.evicted_note  (evicted_note),
		.freed_mask    (freed_mask),
		.sounding_mask (sounding_mask)
	);

endmodule
`default_nettype wire
